FILE: design/utn_pkg.sv
// Package for the UTF-8 text normalizer.
// Holds the shared types, constants and the punctuation lookup; no dependencies.

package utn_pkg;

  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [2:0] CFG_NEWLINE = 3'd0;
  localparam logic [2:0] CFG_TAB = 3'd1;
  localparam logic [2:0] CFG_RESTRICT = 3'd2;
  localparam logic [2:0] CFG_LOWER = 3'd3;
  localparam logic [2:0] CFG_PUNCT = 3'd4;

  localparam logic [1:0] ACT_PASS = 2'd0;
  localparam logic [1:0] ACT_DROP = 2'd1;
  localparam logic [1:0] ACT_HOLD = 2'd2;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] PUNCT_LEAD = 8'he2;
  localparam logic [7:0] PUNCT_MID = 8'h80;

  typedef struct packed {
    logic newline_en;
    logic tab_en;
    logic restrict_en;
    logic lower_en;
    logic punct_en;
  } cfg_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0] n;
    logic last;
  } run_t;

  // Returns {hit, ascii} for the final byte of an E2 80 xx sequence.
  function automatic logic [8:0] punct_map(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      8'h94, 8'h93, 8'h90, 8'h91: r = {1'b1, 8'h2d};
      8'h9c, 8'h9d, 8'hb3: r = {1'b1, 8'h22};
      8'h98, 8'h99, 8'hb2: r = {1'b1, 8'h27};
      8'ha2, 8'ha3: r = {1'b1, 8'h2a};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/utn_if.sv
// Stream interfaces for the UTF-8 text normalizer input and output channels.
// Depends on nothing but the language itself.

interface utn_in_if;
  logic valid;
  logic ready;
  logic [7:0] in_byte;
  logic in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface utn_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic byte_valid;
  logic run_last;
  logic stream_end;
  logic [31:0] bytes_out;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output stream_end, output bytes_out, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input run_last,
                input stream_end, input bytes_out, output ready);
endinterface

FILE: design/utn_front.sv
// Front end: accepts input bytes, tracks UTF-8 sequence state and builds each
// byte's run of up to three result bytes. Depends on utn_pkg and utn_in_if.

module utn_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utn_pkg::cfg_t       cfg_i,
  utn_in_if.sink              in_ch,
  input  logic                q_full_i,
  output logic                push_o,
  output utn_pkg::run_t       run_o
);

  logic       pend_q, pend_d;
  logic [1:0] cont_q, cont_d;
  logic [1:0] act_q, act_d;
  logic [1:0] hcnt_q, hcnt_d;
  logic [7:0] held0_q, held0_d;
  logic [7:0] held1_q, held1_d;
  logic       accept;
  logic [2:0][7:0] ob;
  logic [1:0] n;

  assign in_ch.ready = !q_full_i;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [7:0] b;
    logic [1:0] len;
    logic [8:0] pm;
    logic       plain;
    b = in_ch.in_byte;
    pend_d = pend_q;
    cont_d = cont_q;
    act_d = act_q;
    hcnt_d = hcnt_q;
    held0_d = held0_q;
    held1_d = held1_q;
    ob = '0;
    n = 2'd0;
    pm = utn_pkg::punct_map(b);
    plain = (b >= 8'h20 && b <= 8'h7e) || b == utn_pkg::CH_CR || b == utn_pkg::CH_LF ||
            b == utn_pkg::CH_TAB;
    if (b[7:5] == 3'b110) begin
      len = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      len = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      len = 2'd3;
    end else begin
      len = 2'd0;
    end

    if (cont_q != 2'd0) begin
      cont_d = cont_q - 2'd1;
      case (act_q)
        utn_pkg::ACT_PASS: begin
          ob[n] = b;
          n = n + 2'd1;
        end
        utn_pkg::ACT_HOLD: begin
          if (hcnt_q != 2'd2) begin
            if (b == utn_pkg::PUNCT_MID && cont_d != 2'd0) begin
              held1_d = b;
              hcnt_d = 2'd2;
            end else begin
              hcnt_d = 2'd0;
              if (cfg_i.restrict_en) begin
                ob[n] = utn_pkg::CH_DEL;
                n = n + 2'd1;
                act_d = utn_pkg::ACT_DROP;
              end else begin
                ob[n] = held0_q;
                n = n + 2'd1;
                ob[n] = b;
                n = n + 2'd1;
                act_d = utn_pkg::ACT_PASS;
              end
            end
          end else begin
            hcnt_d = 2'd0;
            act_d = utn_pkg::ACT_PASS;
            if (pm[8]) begin
              ob[n] = pm[7:0];
              n = n + 2'd1;
            end else if (cfg_i.restrict_en) begin
              ob[n] = utn_pkg::CH_DEL;
              n = n + 2'd1;
            end else begin
              ob[n] = held0_q;
              n = n + 2'd1;
              ob[n] = held1_q;
              n = n + 2'd1;
              ob[n] = b;
              n = n + 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (pend_q && b == utn_pkg::CH_LF) begin
      pend_d = 1'b0;
    end else begin
      pend_d = 1'b0;
      act_d = utn_pkg::ACT_PASS;
      hcnt_d = 2'd0;
      if (cfg_i.newline_en && b == utn_pkg::CH_CR) begin
        ob[n] = utn_pkg::CH_LF;
        n = n + 2'd1;
        pend_d = 1'b1;
      end else if (cfg_i.tab_en && b == utn_pkg::CH_TAB) begin
        ob[n] = utn_pkg::CH_SPACE;
        n = n + 2'd1;
      end else if (cfg_i.punct_en && b == utn_pkg::PUNCT_LEAD) begin
        held0_d = b;
        hcnt_d = 2'd1;
        act_d = utn_pkg::ACT_HOLD;
        cont_d = 2'd2;
      end else if (cfg_i.restrict_en && !plain) begin
        ob[n] = utn_pkg::CH_DEL;
        n = n + 2'd1;
        act_d = utn_pkg::ACT_DROP;
        cont_d = len;
      end else if (cfg_i.lower_en && b >= 8'h41 && b <= 8'h5a) begin
        ob[n] = b + 8'd32;
        n = n + 2'd1;
      end else begin
        ob[n] = b;
        n = n + 2'd1;
        cont_d = len;
      end
    end

    if (in_ch.in_last) begin
      if (hcnt_d != 2'd0 && act_d == utn_pkg::ACT_HOLD) begin
        if (cfg_i.restrict_en) begin
          ob[n] = utn_pkg::CH_DEL;
          n = n + 2'd1;
        end else begin
          ob[n] = held0_d;
          n = n + 2'd1;
          if (hcnt_d == 2'd2) begin
            ob[n] = held1_d;
            n = n + 2'd1;
          end
        end
      end
      pend_d = 1'b0;
      cont_d = 2'd0;
      act_d = utn_pkg::ACT_PASS;
      hcnt_d = 2'd0;
    end
  end

  assign push_o = accept && (n != 2'd0 || in_ch.in_last);
  assign run_o = '{bytes: ob, n: n, last: in_ch.in_last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      cont_q <= 2'd0;
      act_q <= utn_pkg::ACT_PASS;
      hcnt_q <= 2'd0;
    end else if (accept) begin
      pend_q <= pend_d;
      cont_q <= cont_d;
      act_q <= act_d;
      hcnt_q <= hcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held0_q <= held0_d;
      held1_q <= held1_d;
    end
  end

endmodule

FILE: design/utn_queue.sv
// Short run queue between the front and back ends of the text normalizer.
// Depends on utn_pkg for the run type and depth.

module utn_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  utn_pkg::run_t wdata_i,
  input  logic          pop_i,
  output utn_pkg::run_t rdata_o,
  output logic          empty_o,
  output logic          full_o
);

  utn_pkg::run_t mem_q [utn_pkg::QDEPTH];
  logic [utn_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [utn_pkg::QPTR_W:0] cnt_q;
  logic do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o = (cnt_q == (utn_pkg::QPTR_W+1)'(utn_pkg::QDEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: design/utn_back.sv
// Back end: walks each queued run, one result per cycle unless the output stalls,
// into an output register and keeps the saturating byte count. Depends on utn_pkg, utn_out_if.

module utn_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  utn_pkg::run_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  utn_out_if.source     out_ch
);

  logic       ov_q;
  logic [1:0] idx_q, idx_d;
  logic [utn_pkg::COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_new;
  logic [7:0] ob_q;
  logic       bv_q, rl_q, se_q;
  logic [31:0] bo_q;
  logic take, bv, rl, se;

  assign take = !empty_i && (!ov_q || out_ch.ready);
  assign bv = (head_i.n != 2'd0);
  assign rl = !bv || (idx_q == head_i.n - 2'd1);
  assign se = rl && head_i.last;
  assign pop_o = take && rl;

  always_comb begin
    cnt_new = cnt_q;
    if (bv && cnt_q != '1) begin
      cnt_new = cnt_q + 1'b1;
    end
    cnt_d = se ? '0 : cnt_new;
    idx_d = rl ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      idx_q <= 2'd0;
      cnt_q <= '0;
    end else if (take) begin
      ov_q <= 1'b1;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end else if (out_ch.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ob_q <= bv ? head_i.bytes[idx_q] : 8'd0;
      bv_q <= bv;
      rl_q <= rl;
      se_q <= se;
      bo_q <= 32'(cnt_new);
    end
  end

  assign out_ch.valid = ov_q;
  assign out_ch.out_byte = ob_q;
  assign out_ch.byte_valid = bv_q;
  assign out_ch.run_last = rl_q;
  assign out_ch.stream_end = se_q;
  assign out_ch.bytes_out = bo_q;

endmodule

FILE: design/utf8_text_normalizer.sv
// Top level of the UTF-8 text normalizer: configuration registers, front end,
// run queue and back end. Depends on utn_pkg, utn_if, utn_front, utn_queue, utn_back.
//
//   Channel  Dir  Beat content                                   Handshake
//   in_ch    in   in_byte, in_last                               valid/ready
//   out_ch   out  out_byte, byte_valid, run_last, stream_end,    valid/ready
//                 bytes_out
//   cfg      in   cfg_idx_i, cfg_data_i                          cfg_we_i
//
// One input byte is accepted per cycle while the four-entry run queue has room.
// Each byte gives zero to three result beats; the back end sends one per cycle
// while its output register is empty or out_ch.ready is high.
// Between a byte and its results lie the run queue and the back end's output register.
// Reset clears all sequence state, the queue and the byte count.
// A stalled output holds its beat while the front end keeps filling the queue.

module utf8_text_normalizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [0:0] cfg_data_i,
  utn_in_if.sink     in_ch,
  utn_out_if.source  out_ch
);

  utn_pkg::cfg_t cfg_q;
  utn_pkg::run_t push_run, head_run;
  logic push, pop, q_empty, q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        utn_pkg::CFG_NEWLINE: cfg_q.newline_en <= cfg_data_i[0];
        utn_pkg::CFG_TAB: cfg_q.tab_en <= cfg_data_i[0];
        utn_pkg::CFG_RESTRICT: cfg_q.restrict_en <= cfg_data_i[0];
        utn_pkg::CFG_LOWER: cfg_q.lower_en <= cfg_data_i[0];
        utn_pkg::CFG_PUNCT: cfg_q.punct_en <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  utn_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_ch    (in_ch),
    .q_full_i (q_full),
    .push_o   (push),
    .run_o    (push_run)
  );

  utn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_run),
    .pop_i   (pop),
    .rdata_o (head_run),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  utn_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_run),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: design/utn_checker.sv
// Port-level checks for the UTF-8 text normalizer, bound to the top level.
// Depends on nothing but the top level's port signals.

module utn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        byte_valid_i,
  input logic        run_last_i,
  input logic        stream_end_i,
  input logic [31:0] bytes_out_i
);

  logic        mid_q;
  logic [31:0] prev_q;
  logic        beat;

  assign beat = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
      prev_q <= '0;
    end else if (beat) begin
      mid_q <= !stream_end_i;
      prev_q <= stream_end_i ? 32'd0 : bytes_out_i;
    end
  end

  // A bare marker only closes a stream.
  a_bare_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !byte_valid_i) |-> (run_last_i && stream_end_i))
    else $error("bare marker that does not end the stream");

  // The stream ends on the last beat of a byte.
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && stream_end_i) |-> run_last_i)
    else $error("stream end without run_last");

  // The count grows by one per byte beat within a stream until it saturates.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && mid_q && byte_valid_i && prev_q != 32'hffffffff) |->
      (bytes_out_i == prev_q + 32'd1))
    else $error("byte count did not advance by one");

  // A bare marker repeats the count of the beat before it in its stream, or zero if it opens the stream.
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !byte_valid_i) |-> (bytes_out_i == prev_q))
    else $error("bare marker count differs from last count");

endmodule

bind utf8_text_normalizer utn_checker u_utn_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .byte_valid_i (out_ch.byte_valid),
  .run_last_i   (out_ch.run_last),
  .stream_end_i (out_ch.stream_end),
  .bytes_out_i  (out_ch.bytes_out)
);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_text_normalizer: directed and random byte streams
// under several register settings, checked beat by beat against a built-in predictor.
// Depends on utn_pkg, the utn_in_if and utn_out_if interfaces and the normalizer RTL.

module tb_top;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam logic [2:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [2:0] CFG_UNUSED_HI = 3'd7;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Each entry holds the third byte of an E2 80 xx sequence and its ASCII stand-in.
  localparam logic [11:0][15:0] PUNCT_TABLE = {
    16'h942d, 16'h932d, 16'h902d, 16'h912d, 16'h9c22, 16'h9d22,
    16'hb322, 16'h9827, 16'h9927, 16'hb227, 16'ha22a, 16'ha32a};

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        stream_end;
    logic [31:0] bytes_out;
  } beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [0:0] cfg_data_i;

  utn_in_if  in_ch();
  utn_out_if out_ch();

  utf8_text_normalizer u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  utn_pkg::cfg_t shadow_cfg = '0;
  logic        cr_seen = 1'b0;
  logic [1:0]  cont_left = 2'd0;
  logic [1:0]  seq_act = utn_pkg::ACT_PASS;
  logic [7:0]  held0 = 8'd0;
  logic [7:0]  held1 = 8'd0;
  logic [1:0]  held_n = 2'd0;
  logic [31:0] out_count = 32'd0;
  beat_t       step_beats[3];
  int          step_n;
  beat_t       due_beats[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [2:0] utf8_len(input logic [7:0] b);
    if (b[7:5] == 3'b110) return 3'd2;
    if (b[7:4] == 4'b1110) return 3'd3;
    if (b[7:3] == 5'b11110) return 3'd4;
    return 3'd1;
  endfunction

  function automatic logic is_plain(input logic [7:0] b);
    return (b >= utn_pkg::CH_SPACE && b <= CH_TILDE) || b == utn_pkg::CH_CR ||
           b == utn_pkg::CH_LF || b == utn_pkg::CH_TAB;
  endfunction

  // Returns {found, ascii} for the third byte of a punctuation sequence.
  function automatic logic [8:0] punct_lookup(input logic [7:0] tail);
    logic [8:0] r;
    r = 9'd0;
    for (int i = 0; i < 12; i++) begin
      if (PUNCT_TABLE[i][15:8] == tail) r = {1'b1, PUNCT_TABLE[i][7:0]};
    end
    return r;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    if (step_n >= 3) return;
    if (out_count != '1) out_count++;
    step_beats[step_n] = '{b, 1'b1, 1'b0, 1'b0, out_count};
    step_n++;
  endfunction

  // Works out the beats caused by one accepted input byte and queues them.
  function automatic void normalize_byte(input logic [7:0] b, input logic last);
    logic [2:0] len;
    logic [8:0] hit;
    step_n = 0;
    if (cont_left != 2'd0) begin
      cont_left = cont_left - 2'd1;
      if (seq_act == utn_pkg::ACT_PASS) begin
        emit_byte(b);
      end else if (seq_act == utn_pkg::ACT_HOLD) begin
        if (held_n < 2'd2) begin
          if (held0 == utn_pkg::PUNCT_LEAD && b == utn_pkg::PUNCT_MID &&
              cont_left != 2'd0) begin
            held1 = b;
            held_n = 2'd2;
          end else begin
            held_n = 2'd0;
            if (shadow_cfg.restrict_en) begin
              emit_byte(utn_pkg::CH_DEL);
              seq_act = utn_pkg::ACT_DROP;
            end else begin
              emit_byte(held0);
              emit_byte(b);
              seq_act = utn_pkg::ACT_PASS;
            end
          end
        end else begin
          hit = punct_lookup(b);
          held_n = 2'd0;
          seq_act = utn_pkg::ACT_PASS;
          if (held0 == utn_pkg::PUNCT_LEAD && held1 == utn_pkg::PUNCT_MID && hit[8]) begin
            emit_byte(hit[7:0]);
          end else if (shadow_cfg.restrict_en) begin
            emit_byte(utn_pkg::CH_DEL);
          end else begin
            emit_byte(held0);
            emit_byte(held1);
            emit_byte(b);
          end
        end
      end
    end else if (cr_seen && b == utn_pkg::CH_LF) begin
      cr_seen = 1'b0;
    end else begin
      len = utf8_len(b);
      cr_seen = 1'b0;
      seq_act = utn_pkg::ACT_PASS;
      held_n = 2'd0;
      if (shadow_cfg.newline_en && b == utn_pkg::CH_CR) begin
        emit_byte(utn_pkg::CH_LF);
        cr_seen = 1'b1;
      end else if (shadow_cfg.tab_en && b == utn_pkg::CH_TAB) begin
        emit_byte(utn_pkg::CH_SPACE);
      end else if (shadow_cfg.punct_en && len == 3'd3 && b == utn_pkg::PUNCT_LEAD) begin
        held0 = b;
        held_n = 2'd1;
        seq_act = utn_pkg::ACT_HOLD;
        cont_left = 2'd2;
      end else if (shadow_cfg.restrict_en && !is_plain(b)) begin
        emit_byte(utn_pkg::CH_DEL);
        seq_act = utn_pkg::ACT_DROP;
        cont_left = 2'(len - 3'd1);
      end else if (shadow_cfg.lower_en && b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
        emit_byte(b + CASE_OFFSET);
      end else begin
        emit_byte(b);
        cont_left = 2'(len - 3'd1);
      end
    end
    if (last) begin
      if (held_n != 2'd0 && seq_act == utn_pkg::ACT_HOLD) begin
        if (shadow_cfg.restrict_en) begin
          emit_byte(utn_pkg::CH_DEL);
        end else begin
          emit_byte(held0);
          if (held_n >= 2'd2) emit_byte(held1);
        end
      end
      if (step_n == 0) begin
        step_beats[0] = '{8'd0, 1'b0, 1'b0, 1'b0, out_count};
        step_n = 1;
      end
      step_beats[step_n - 1].stream_end = 1'b1;
      cr_seen = 1'b0;
      cont_left = 2'd0;
      seq_act = utn_pkg::ACT_PASS;
      held_n = 2'd0;
      out_count = 32'd0;
    end
    if (step_n > 0) step_beats[step_n - 1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++) due_beats.push_back(step_beats[i]);
  endfunction

  always @(posedge clk_i) begin
    beat_t got;
    beat_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_byte, out_ch.byte_valid, out_ch.run_last, out_ch.stream_end,
              out_ch.bytes_out};
      if (due_beats.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected beat: byte %02h valid %0b last %0b end %0b count %0d",
                   got.out_byte, got.byte_valid, got.run_last, got.stream_end,
                   got.bytes_out);
      end else begin
        want = due_beats.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
            got.run_last !== want.run_last || got.stream_end !== want.stream_end ||
            got.bytes_out !== want.bytes_out) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("beat mismatch: expected %02h/%0b/%0b/%0b/%0d got %02h/%0b/%0b/%0b/%0d",
                     want.out_byte, want.byte_valid, want.run_last, want.stream_end,
                     want.bytes_out, got.out_byte, got.byte_valid, got.run_last,
                     got.stream_end, got.bytes_out);
        end
      end
    end
    out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    normalize_byte(b, last);
  endtask

  // The sender holds off until every expected beat is out and the pipeline has drained.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (due_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    case (idx)
      utn_pkg::CFG_NEWLINE:  shadow_cfg.newline_en = v;
      utn_pkg::CFG_TAB:      shadow_cfg.tab_en = v;
      utn_pkg::CFG_RESTRICT: shadow_cfg.restrict_en = v;
      utn_pkg::CFG_LOWER:    shadow_cfg.lower_en = v;
      utn_pkg::CFG_PUNCT:    shadow_cfg.punct_en = v;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input utn_pkg::cfg_t c);
    int idx;
    wait_idle();
    write_register(utn_pkg::CFG_NEWLINE, c.newline_en);
    write_register(utn_pkg::CFG_TAB, c.tab_en);
    write_register(utn_pkg::CFG_RESTRICT, c.restrict_en);
    write_register(utn_pkg::CFG_LOWER, c.lower_en);
    write_register(utn_pkg::CFG_PUNCT, c.punct_en);
    for (idx = CFG_UNUSED_LO; idx <= CFG_UNUSED_HI; idx++)
      write_register(3'(idx), 1'($urandom_range(1, 0)));
  endtask

  task automatic set_idling(input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
  endtask

  // Mostly well-formed text with random content, plus near misses and raw noise.
  task automatic send_text(input int n_bytes);
    logic [7:0] tok [4];
    int tok_n;
    int sent;
    int pick;
    int k;
    logic last;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99, 0);
      tok_n = 1;
      if (pick < 28) begin
        tok[0] = 8'($urandom_range(CH_TILDE, utn_pkg::CH_SPACE));
      end else if (pick < 38) begin
        tok[0] = 8'($urandom_range(CH_UPPER_Z, CH_UPPER_A));
      end else if (pick < 44) begin
        tok[0] = utn_pkg::CH_CR;
      end else if (pick < 50) begin
        tok[0] = utn_pkg::CH_CR;
        tok[1] = utn_pkg::CH_LF;
        tok_n = 2;
      end else if (pick < 53) begin
        tok[0] = utn_pkg::CH_LF;
      end else if (pick < 57) begin
        tok[0] = utn_pkg::CH_TAB;
      end else if (pick < 71) begin
        tok[0] = utn_pkg::PUNCT_LEAD;
        tok[1] = utn_pkg::PUNCT_MID;
        tok[2] = PUNCT_TABLE[$urandom_range(11, 0)][15:8];
        tok_n = 3;
      end else if (pick < 77) begin
        tok[0] = utn_pkg::PUNCT_LEAD;
        tok[1] = ($urandom_range(1, 0) == 0) ? utn_pkg::PUNCT_MID :
                 8'($urandom_range(255, 0));
        tok[2] = 8'($urandom_range(255, 0));
        tok_n = 3;
      end else if (pick < 86) begin
        tok_n = $urandom_range(4, 2);
        case (tok_n)
          2: tok[0] = {3'b110, 5'($urandom_range(31, 0))};
          3: tok[0] = {4'b1110, 4'($urandom_range(15, 0))};
          default: tok[0] = {5'b11110, 3'($urandom_range(7, 0))};
        endcase
        for (k = 1; k < tok_n; k++) tok[k] = {2'b10, 6'($urandom_range(63, 0))};
      end else begin
        tok[0] = 8'($urandom_range(255, 0));
      end
      for (k = 0; k < tok_n && sent < n_bytes; k++) begin
        sent++;
        last = (sent == n_bytes) || ($urandom_range(15, 0) == 0);
        send_byte(tok[k], last);
      end
    end
  endtask

  task automatic test_pass_through();
    send_byte(CH_UPPER_A, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_all_rules();
    apply_config('1);
    send_byte(utn_pkg::CH_CR, 1'b0);
    send_byte(utn_pkg::CH_LF, 1'b0);
    send_byte(utn_pkg::CH_TAB, 1'b0);
    send_byte(CH_UPPER_Z, 1'b0);
    send_byte(utn_pkg::PUNCT_LEAD, 1'b0);
    send_byte(utn_pkg::PUNCT_MID, 1'b0);
    send_byte(8'h94, 1'b0);
    send_byte(utn_pkg::PUNCT_LEAD, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(CH_UPPER_A, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'ha9, 1'b0);
    send_byte(8'h1f, 1'b1);
  endtask

  task automatic test_stream_end_markers();
    send_byte(utn_pkg::CH_CR, 1'b0);
    send_byte(utn_pkg::CH_LF, 1'b1);
    send_byte(utn_pkg::PUNCT_LEAD, 1'b1);
  endtask

  task automatic test_punct_fallback();
    utn_pkg::cfg_t c;
    c = '0;
    c.punct_en = 1'b1;
    apply_config(c);
    send_byte(utn_pkg::PUNCT_LEAD, 1'b0);
    send_byte(utn_pkg::PUNCT_MID, 1'b0);
    send_byte(CH_UPPER_A, 1'b0);
    send_byte(utn_pkg::PUNCT_LEAD, 1'b0);
    send_byte(CH_UPPER_A, 1'b0);
    send_byte(CH_UPPER_Z, 1'b0);
    send_byte(utn_pkg::PUNCT_LEAD, 1'b0);
    send_byte(utn_pkg::PUNCT_MID, 1'b1);
  endtask

  // The restricted option is read again when a held sequence is resolved.
  task automatic test_cfg_mid_sequence();
    send_byte(utn_pkg::PUNCT_LEAD, 1'b0);
    send_byte(utn_pkg::PUNCT_MID, 1'b0);
    wait_idle();
    write_register(utn_pkg::CFG_RESTRICT, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random_text(input int s_pct, input int r_pct,
                                  input utn_pkg::cfg_t first_cfg);
    int run;
    set_idling(s_pct, r_pct);
    for (run = 0; run < 3; run++) begin
      apply_config((run == 0) ? first_cfg :
                   utn_pkg::cfg_t'(5'($urandom_range(31, 0))));
      send_text(8);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = utn_pkg::CFG_NEWLINE;
    cfg_data_i = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'd0;
    in_ch.in_last = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idling(33, 60);
    test_pass_through();
    test_all_rules();
    test_stream_end_markers();
    test_punct_fallback();
    test_cfg_mid_sequence();
    test_random_text(33, 60, '1);
    test_random_text(60, 33, '0);
    test_random_text(0, 0, utn_pkg::cfg_t'(5'($urandom_range(31, 0))));
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/utn_pkg.sv
design/utn_if.sv
design/utn_front.sv
design/utn_queue.sv
design/utn_back.sv
design/utf8_text_normalizer.sv
design/utn_checker.sv
sim/tb_top.sv
